// ----- rtl/olist_pkg.sv -----
package olist_pkg;

    // default list capacity
    localparam int LIST_DEPTH_DEF = 16;

    // field widths fixed by the stream format
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FIRST = 3'd0,
        FN_INS_LAST  = 3'd1,
        FN_INS_AT    = 3'd2,
        FN_DEL_FIRST = 3'd3,
        FN_DEL_LAST  = 3'd4,
        FN_DEL_AT    = 3'd5,
        FN_FIND      = 3'd6
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // what every cell does in a cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INS,
        OP_DEL,
        OP_LOAD,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [VALUE_W-1:0] value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ----- rtl/olist_cell.sv -----
module olist_cell #(
    parameter int LIST_DEPTH = olist_pkg::LIST_DEPTH_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                                   i_clk,
    input  olist_pkg::t_cell_ctl                   i_ctl,
    input  logic [$clog2(LIST_DEPTH)-1:0]          i_p,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]        i_count,
    input  logic [olist_pkg::VALUE_W-1:0]          i_left_data,
    input  logic [olist_pkg::VALUE_W-1:0]          i_right_data,
    input  logic [olist_pkg::VALUE_W-1:0]          i_right_tap,
    input  logic                                   i_right_flag,
    output logic [olist_pkg::VALUE_W-1:0]          o_data,
    output logic [olist_pkg::VALUE_W-1:0]          o_tap,
    output logic                                   o_flag
);
    import olist_pkg::*;

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [IW-1:0] MY_IDX   = IW'(CELL_IDX);
    localparam logic [CW-1:0] MY_COUNT = CW'(CELL_IDX);

    logic [VALUE_W-1:0] r_data;
    logic [VALUE_W-1:0] r_tap;
    logic               r_flag;

    // stored entry plus a read tap that drains toward cell zero
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_INS: begin
                if (MY_IDX > i_p) begin
                    r_data <= i_left_data;
                end else if (MY_IDX == i_p) begin
                    r_data <= i_ctl.value;
                end
            end
            OP_DEL: begin
                if (MY_IDX >= i_p) begin
                    r_data <= i_right_data;
                end
            end
            OP_LOAD: begin
                r_tap  <= r_data;
                r_flag <= (r_data == i_ctl.value) && (MY_COUNT < i_count);
            end
            OP_SHIFT: begin
                r_tap  <= i_right_tap;
                r_flag <= i_right_flag;
            end
            OP_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;
    assign o_flag = r_flag;

endmodule

// ----- rtl/ordered_list_engine_unit.sv -----
// ordered list of up to LIST_DEPTH signed 32-bit values held in a row of cells,
// one entry per cell, position 0 in cell 0. a request beat carries the operation
// in tuser and the value and position in tdata; each request gives exactly one
// result beat with status in tuser and removed value, found index and new count
// in tdata. inserts, the unused code and all error cases pass from the request beat
// through the exec state to the done state, which loads the result register once
// the output register is free. find and the three deletes first copy every cell
// into a read tap chain that moves one position toward cell 0 per cycle, and walk
// it in the scan state until cell 0 holds the target: the first match (or the last
// entry on a miss) for find, the deleted position for delete; done then loads the
// result register the same way. one request is in work at a time; a finished
// result sits in the output register, so the next request is taken while the
// previous result still waits for the downstream side.
module ordered_list_engine_unit #(
    parameter int LIST_DEPTH = olist_pkg::LIST_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // item_value[31:0], position[36:32], zero pad
    input  logic [2:0]  i_s_axis_tuser,   // func[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // removed_value[31:0], found_index[35:32],
                                          // entry_count[40:36], zero pad
    output logic [2:0]  o_m_axis_tuser    // status[2:0]
);
    import olist_pkg::*;

    localparam int IW   = $clog2(LIST_DEPTH);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_o_valid, n_o_valid;

    // request and working registers
    t_func               r_func, n_func;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [IW-1:0]       r_p, n_p;
    logic [IW-1:0]       r_scan, n_scan;
    t_status             r_status, n_status;
    logic [VALUE_W-1:0]  r_removed, n_removed;
    logic [IW-1:0]       r_found, n_found;

    // output register
    t_status             r_o_status, n_o_status;
    logic [VALUE_W-1:0]  r_o_removed, n_o_removed;
    logic [FOUND_W-1:0]  r_o_found, n_o_found;
    logic [COUNT_W-1:0]  r_o_count, n_o_count;

    // cell row
    t_cell_ctl           w_ctl;
    logic [IW-1:0]       w_p;
    logic [VALUE_W-1:0]  w_data [LIST_DEPTH];
    logic [VALUE_W-1:0]  w_tap  [LIST_DEPTH];
    logic                w_flag [LIST_DEPTH];

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            logic [VALUE_W-1:0] w_left_data;
            logic [VALUE_W-1:0] w_right_data;
            logic [VALUE_W-1:0] w_right_tap;
            logic               w_right_flag;

            // ends of the row see zeros
            if (g == 0) begin : g_first
                assign w_left_data = '0;
            end else begin : g_inner_l
                assign w_left_data = w_data[g-1];
            end
            if (g == LIST_DEPTH - 1) begin : g_last
                assign w_right_data = '0;
                assign w_right_tap  = '0;
                assign w_right_flag = 1'b0;
            end else begin : g_inner_r
                assign w_right_data = w_data[g+1];
                assign w_right_tap  = w_tap[g+1];
                assign w_right_flag = w_flag[g+1];
            end

            olist_cell #(
                .LIST_DEPTH (LIST_DEPTH),
                .CELL_IDX   (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_p          (w_p),
                .i_count      (r_count),
                .i_left_data  (w_left_data),
                .i_right_data (w_right_data),
                .i_right_tap  (w_right_tap),
                .i_right_flag (w_right_flag),
                .o_data       (w_data[g]),
                .o_tap        (w_tap[g]),
                .o_flag       (w_flag[g])
            );
        end
    endgenerate

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_val       <= n_val;
        r_pos       <= n_pos;
        r_p         <= n_p;
        r_scan      <= n_scan;
        r_status    <= n_status;
        r_removed   <= n_removed;
        r_found     <= n_found;
        r_o_status  <= n_o_status;
        r_o_removed <= n_o_removed;
        r_o_found   <= n_o_found;
        r_o_count   <= n_o_count;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_o_valid   = r_o_valid && !i_m_axis_tready;
        n_func      = r_func;
        n_val       = r_val;
        n_pos       = r_pos;
        n_p         = r_p;
        n_scan      = r_scan;
        n_status    = r_status;
        n_removed   = r_removed;
        n_found     = r_found;
        n_o_status  = r_o_status;
        n_o_removed = r_o_removed;
        n_o_found   = r_o_found;
        n_o_count   = r_o_count;
        w_ctl.op    = OP_HOLD;
        w_ctl.value = r_val;
        w_p         = r_p;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_func  = t_func'(i_s_axis_tuser);
                    n_val   = i_s_axis_tdata[31:0];
                    n_pos   = i_s_axis_tdata[36:32];
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_removed = '0;
                n_found   = '0;
                n_state   = S_DONE;
                unique case (r_func)
                    FN_INS_FIRST, FN_INS_LAST, FN_INS_AT: begin
                        // index check comes before the full check
                        if (r_func == FN_INS_AT && CMPW'(r_pos) > CMPW'(r_count)) begin
                            n_status = ST_BAD_INDEX;
                        end else if (r_count == CW'(LIST_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctl.op = OP_INS;
                            w_p      = (r_func == FN_INS_FIRST) ? '0 :
                                       (r_func == FN_INS_LAST)  ? IW'(r_count) : IW'(r_pos);
                            n_count  = r_count + 1'b1;
                            n_status = ST_OK;
                        end
                    end
                    FN_DEL_FIRST, FN_DEL_LAST, FN_DEL_AT: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (r_func == FN_DEL_AT &&
                                     CMPW'(r_pos) >= CMPW'(r_count)) begin
                            n_status = ST_BAD_INDEX;
                        end else begin
                            // copy the row into the taps, then walk to the target
                            w_ctl.op = OP_LOAD;
                            n_p      = (r_func == FN_DEL_FIRST) ? '0 :
                                       (r_func == FN_DEL_LAST)  ? IW'(r_count - 1'b1) :
                                                                  IW'(r_pos);
                            n_scan   = '0;
                            n_state  = S_SCAN;
                        end
                    end
                    FN_FIND: begin
                        if (r_count == '0) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            // every cell compares at once, flags drain with the taps
                            w_ctl.op = OP_LOAD;
                            n_scan   = '0;
                            n_state  = S_SCAN;
                        end
                    end
                    default: begin
                        // unused code: no change
                        n_status = ST_OK;
                    end
                endcase
            end

            S_SCAN: begin
                // cell 0 tap now holds the entry at index r_scan
                if (r_func == FN_FIND) begin
                    if (w_flag[0]) begin
                        n_found  = r_scan;
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (CW'(r_scan) == r_count - 1'b1) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        w_ctl.op = OP_SHIFT;
                        n_scan   = r_scan + 1'b1;
                    end
                end else begin
                    if (r_scan == r_p) begin
                        n_removed = w_tap[0];
                        w_ctl.op  = OP_DEL;
                        w_p       = r_p;
                        n_count   = r_count - 1'b1;
                        n_status  = ST_OK;
                        n_state   = S_DONE;
                    end else begin
                        w_ctl.op = OP_SHIFT;
                        n_scan   = r_scan + 1'b1;
                    end
                end
            end

            S_DONE: begin
                // hand over once the output register is free
                if (!r_o_valid || i_m_axis_tready) begin
                    n_o_valid   = 1'b1;
                    n_o_status  = r_status;
                    n_o_removed = r_removed;
                    n_o_found   = FOUND_W'(r_found);
                    n_o_count   = COUNT_W'(r_count);
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tdata  = {7'b0, r_o_count, r_o_found, r_o_removed};

    // count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("entry count above capacity");

    // count moves by at most one per request
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == CW'($past(r_count) + 1'b1) ||
             r_count == CW'($past(r_count) - 1'b1)))
        else $error("entry count jumped");

    // the tap walk stays inside the live entries
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_scan) < r_count))
        else $error("scan past last entry");

    // a full answer reports a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ST_FULL) |->
            (o_m_axis_tdata[40:36] == COUNT_W'(LIST_DEPTH)))
        else $error("full status with room left");

endmodule

// ----- test/olist_checker.sv -----
module olist_checker #(
    parameter int LIST_DEPTH = olist_pkg::LIST_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // item_value[31:0], position[36:32], zero pad
    input  logic [2:0]  i_s_tuser,   // func[2:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // removed_value[31:0], found_index[35:32],
                                     // entry_count[40:36], zero pad
    input  logic [2:0]  i_m_tuser,   // status[2:0]
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import olist_pkg::*;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   removed;
        logic [FOUND_W-1:0]   found;
        logic [COUNT_W-1:0]   count;
    } t_list_result;

    // shadow copy of the list contents
    logic [VALUE_W-1:0] shadow_list [LIST_DEPTH];
    int                 shadow_count = 0;
    t_list_result       pending_results [$];
    int                 mismatches = 0;
    int                 waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic t_status open_slot(int at, logic [VALUE_W-1:0] value);
        int i;
        if (shadow_count >= LIST_DEPTH) return ST_FULL;
        for (i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[at] = value;
        shadow_count++;
        return ST_OK;
    endfunction

    function automatic t_status close_slot(int at, output logic [VALUE_W-1:0] taken);
        int i;
        taken = '0;
        if (shadow_count == 0) return ST_EMPTY;
        if (at >= shadow_count) return ST_BAD_INDEX;
        taken = shadow_list[at];
        for (i = at; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
        shadow_count--;
        return ST_OK;
    endfunction

    function automatic t_list_result apply_request(t_func op, logic [VALUE_W-1:0] value,
                                                   int pos);
        t_list_result       r;
        logic [VALUE_W-1:0] taken;
        int                 i;
        r.status  = ST_OK;
        r.removed = '0;
        r.found   = '0;
        taken     = '0;
        case (op)
            FN_INS_FIRST: r.status = open_slot(0, value);
            FN_INS_LAST:  r.status = open_slot(shadow_count, value);
            FN_INS_AT: begin
                if (pos > shadow_count) r.status = ST_BAD_INDEX;
                else r.status = open_slot(pos, value);
            end
            FN_DEL_FIRST: r.status = close_slot(0, taken);
            FN_DEL_LAST:  r.status = close_slot(shadow_count == 0 ? 0 : shadow_count - 1, taken);
            FN_DEL_AT:    r.status = close_slot(pos, taken);
            FN_FIND: begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_list[i] == value) begin
                        r.status = ST_OK;
                        r.found  = FOUND_W'(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
        if (r.status == ST_OK) r.removed = taken;
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_list_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with no request waiting, status %0d",
                             $time, i_m_tuser);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_m_tuser));
                    check_field("removed_value", want.removed, i_m_tdata[31:0]);
                    check_field("found_index", 32'(want.found), 32'(i_m_tdata[35:32]));
                    check_field("entry_count", 32'(want.count), 32'(i_m_tdata[40:36]));
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(apply_request(t_func'(i_s_tuser),
                                                        i_s_tdata[31:0],
                                                        int'(i_s_tdata[36:32])));
        end
        waiting = pending_results.size();
    end

endmodule

// ----- test/ordered_list_engine_unit_tb.sv -----
module ordered_list_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import olist_pkg::*;

    localparam int DEPTH        = LIST_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 650;
    // worst case per request: full-depth scan plus long gaps on both sides
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // request side
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // item_value[31:0], position[36:32], zero pad
    logic [2:0]  s_tuser = '0;   // func[2:0]

    // result side
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // removed_value[31:0], found_index[35:32],
                                 // entry_count[40:36], zero pad
    logic [2:0]  m_tuser;        // status[2:0]

    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          stall_left = 0;
    bit          sender_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    logic [31:0] value_pool [8];

    always #10 clk = ~clk;

    ordered_list_engine_unit #(
        .LIST_DEPTH      (DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    olist_checker #(
        .LIST_DEPTH   (DEPTH)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // one request beat; valid stays high across back-to-back beats
    task automatic send_req(t_func op, logic [31:0] value, logic [4:0] pos);
        int gap;
        gap = sender_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, pos, value};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
        end
    end

    initial begin : stimulus
        int          n;
        int          k;
        int          r;
        bit          grow;
        t_func       op;
        logic [31:0] value;
        logic [4:0]  pos;

        // small pool so finds hit and duplicates show up
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'hffff_ffff;
        value_pool[3] = 32'h0000_0000;
        for (n = 4; n < 8; n++) value_pool[n] = $urandom();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // every delete and a find on an empty list, insert past the end
        send_req(FN_DEL_FIRST, 32'h0, 5'd0);
        send_req(FN_DEL_LAST, 32'h0, 5'd0);
        send_req(FN_DEL_AT, 32'h0, 5'd0);
        send_req(FN_FIND, 32'h0, 5'd0);
        send_req(FN_INS_AT, 32'h1234_5678, 5'd1);

        // extreme values, find at front and back
        send_req(FN_INS_AT, 32'h8000_0000, 5'd0);
        send_req(FN_INS_FIRST, 32'h7fff_ffff, 5'd0);
        send_req(FN_INS_LAST, 32'hffff_ffff, 5'd0);
        send_req(FN_FIND, 32'h7fff_ffff, 5'd0);
        send_req(FN_FIND, 32'hffff_ffff, 5'd0);

        // delete at the count and at the list capacity
        send_req(FN_DEL_AT, 32'h0, 5'd3);
        send_req(FN_DEL_AT, 32'h0, 5'd16);

        // fill up to capacity, alternating insert at the end and insert last
        for (k = 3; k < DEPTH; k++) begin
            if (k % 2) send_req(FN_INS_AT, 32'h1 << k, 5'(k));
            else send_req(FN_INS_LAST, ~(32'h1 << k), 5'd0);
        end

        // inserts into a full list, insert at the count when full
        send_req(FN_INS_FIRST, 32'h0, 5'd0);
        send_req(FN_INS_LAST, 32'h0, 5'd0);
        send_req(FN_INS_AT, 32'h0, 5'd16);

        // find the last entry, then take from the back, the end and the front
        send_req(FN_FIND, 32'h1 << 15, 5'd0);
        send_req(FN_DEL_AT, 32'h0, 5'd15);
        send_req(FN_DEL_LAST, 32'h0, 5'd0);
        send_req(FN_DEL_FIRST, 32'h0, 5'd0);

        // random part: growth and drain phases picked at random so the list swings
        // between empty and full
        grow = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                sender_idle_on = ($urandom_range(0, 3) != 0);
                sink_idle_on   = ($urandom_range(0, 3) != 0);
            end
            if (n % 40 == 0) grow = $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (grow) begin
                if (r < 22)      op = FN_INS_FIRST;
                else if (r < 44) op = FN_INS_LAST;
                else if (r < 65) op = FN_INS_AT;
                else if (r < 73) op = FN_DEL_FIRST;
                else if (r < 80) op = FN_DEL_LAST;
                else if (r < 87) op = FN_DEL_AT;
                else             op = FN_FIND;
            end else begin
                if (r < 7)       op = FN_INS_FIRST;
                else if (r < 14) op = FN_INS_LAST;
                else if (r < 20) op = FN_INS_AT;
                else if (r < 42) op = FN_DEL_FIRST;
                else if (r < 63) op = FN_DEL_LAST;
                else if (r < 85) op = FN_DEL_AT;
                else             op = FN_FIND;
            end
            if ($urandom_range(0, 99) < (op == FN_FIND ? 80 : 50))
                value = value_pool[$urandom_range(0, 7)];
            else
                value = $urandom();
            if ($urandom_range(0, 2) == 0) pos = 5'($urandom_range(0, 3));
            else pos = 5'($urandom_range(0, 16));
            send_req(op, value, pos);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (pending != 0) @(negedge clk);
        repeat (DEPTH + 8) @(negedge clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
